[rtl/fdm_pkg.sv]
package fdm_pkg;

   // Fixed widths of the register file and the result fields.
   localparam int APP_START_W = 48;
   localparam int SCALE_W     = 32;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_IDX_W   = 1;
   localparam int MEDIAN_W    = 64;
   localparam int PAIR_W      = 7;
   localparam int PROD_W      = MEDIAN_W + SCALE_W;
   localparam int QUOT_W      = PROD_W - 16;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_APP_START  = 1'b0,
      CSR_TICK_SCALE = 1'b1
   } csr_idx_type;

   // Request opcodes.
   typedef enum logic {
      FUNC_RECORD = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   localparam logic [SCALE_W-1:0]  SCALE_RESET = 32'h0001_0000;
   localparam logic [MEDIAN_W-1:0] MEDIAN_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [MEDIAN_W-1:0] MEDIAN_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [PAIR_W-1:0]   PAIR_MAX    = 7'd127;

endpackage

[rtl/frame_delta_median_top.sv]
// Frame delta median.
// The request channel carries a function bit and a timestamp. A record
// request stores the elapsed tick count into a ring of DEPTH entries and
// gives no response. A query request gives one
// response: the upper median of the deltas between adjacent valid ring
// entries, scaled by the Q16.16 tick scale and saturated, plus a flag and
// the pair count.
// A query is found by radix selection: one pass over the ring counts the
// valid pairs, then one pass per key bit (TIME_WIDTH+1 of them) counts the
// pairs under the current prefix. Each pass reads the ring RAM through its
// single read port at one entry per cycle. The request side is not ready
// while a query runs. After reset the ring is cleared by a sweep over all
// DEPTH entries, during which no request is taken; register writes are
// taken at any time. The response sits in an output register until the
// receiver takes it; a stalled receiver only holds back the end of the
// next query.
module frame_delta_median_top #(
   parameter int DEPTH      = 128,
   parameter int TIME_WIDTH = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [TIME_WIDTH-1:0]              req_timestamp,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fdm_pkg::MEDIAN_W-1:0] rsp_median_scaled,
   output logic                               rsp_has_data,
   output logic [fdm_pkg::PAIR_W-1:0]         rsp_pair_count,
   input  logic                               csr_wen,
   input  logic [fdm_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [fdm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import fdm_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH);
   localparam int KW  = TIME_WIDTH + 1;
   localparam int XTW = (TIME_WIDTH > APP_START_W) ? TIME_WIDTH : APP_START_W;
   localparam int XCW = (CW > PAIR_W) ? CW : PAIR_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PASS_END,
      ST_MAG,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ROUND,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic                     issuing_ff, issuing_in;
   logic                     dv_ff, dv_in;
   logic                     d_first_ff, d_first_in;
   logic                     d_last_ff, d_last_in;
   logic                     counting_ff, counting_in;
   logic [AW-1:0]            wi_ff, wi_in;
   logic [APP_START_W-1:0]   app_start_ff, app_start_in;
   logic [SCALE_W-1:0]       tick_scale_ff, tick_scale_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TIME_WIDTH-1:0]    prev_ff, prev_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            total_ff, total_in;
   logic [CW-1:0]            rank_ff, rank_in;
   logic [KW-1:0]            prefix_ff, prefix_in;
   logic [KW-1:0]            hi_mask_ff, hi_mask_in;
   logic [KW-1:0]            bit_ff, bit_in;
   logic                     neg_ff, neg_in;
   logic [MEDIAN_W-1:0]      mag_ff, mag_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [QUOT_W-1:0]        q_ff, q_in;
   logic [MEDIAN_W-1:0]      rsp_median_ff, rsp_median_in;
   logic                     rsp_has_ff, rsp_has_in;
   logic [PAIR_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [TIME_WIDTH-1:0]    ram_wdata;
   logic [AW-1:0]            ram_raddr;
   logic [TIME_WIDTH-1:0]    ram_rdata;

   logic [AW-1:0]            oldest;
   logic [AW:0]              raddr_sum;
   logic [XTW-1:0]           elapsed_x;
   logic [KW-1:0]            delta;
   logic [KW-1:0]            key;
   logic                     pair_ok;
   logic                     key_hit;
   logic signed [KW-1:0]     med_s;
   logic [MEDIAN_W-1:0]      med_x;
   logic [XCW-1:0]           total_x;
   logic                     req_fire;

   fdm_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The slot after the newest one holds the oldest entry and takes the next record.
   assign oldest    = (wi_ff == LAST_ADDR) ? '0 : wi_ff + AW'(1);
   assign raddr_sum = {1'b0, oldest} + {1'b0, idx_ff};
   assign ram_raddr = (raddr_sum >= (AW + 1)'(DEPTH)) ?
                      AW'(raddr_sum - (AW + 1)'(DEPTH)) : raddr_sum[AW-1:0];

   // Elapsed ticks of a record request, wrapped to the time width.
   assign elapsed_x = XTW'(req_timestamp) - XTW'(app_start_ff);

   // Pair under the shared compare unit: newer entry on the read port, older one held.
   assign delta   = {1'b0, ram_rdata} - {1'b0, prev_ff};
   assign key     = {~delta[KW-1], delta[KW-2:0]};
   assign pair_ok = dv_ff && !d_first_ff && (ram_rdata != '0) && (prev_ff != '0);
   assign key_hit = (((key ^ prefix_ff) & hi_mask_ff) == '0) && ((key & bit_ff) == '0);

   // Selected key back to a signed delta.
   assign med_s   = {~prefix_ff[KW-1], prefix_ff[KW-2:0]};
   assign med_x   = MEDIAN_W'(med_s);
   assign total_x = XCW'(total_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      issuing_in    = 1'b0;
      dv_in         = 1'b0;
      d_first_in    = (idx_ff == '0);
      d_last_in     = (idx_ff == LAST_ADDR);
      counting_in   = counting_ff;
      wi_in         = wi_ff;
      app_start_in  = app_start_ff;
      tick_scale_in = tick_scale_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      prev_in       = prev_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      rank_in       = rank_ff;
      prefix_in     = prefix_ff;
      hi_mask_in    = hi_mask_ff;
      bit_in        = bit_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      acc_in        = acc_ff;
      q_in          = q_ff;
      rsp_median_in = rsp_median_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = oldest;
      ram_wdata     = elapsed_x[TIME_WIDTH-1:0];

      // Register writes are taken in any state.
      if (csr_wen) begin
         case (csr_idx_type'(csr_idx))
            CSR_APP_START:  app_start_in  = csr_wdata[APP_START_W-1:0];
            CSR_TICK_SCALE: tick_scale_in = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end

      // Data side of the scan: count pairs that pass the current filter.
      if (dv_ff) begin
         prev_in = ram_rdata;
         if (pair_ok && (counting_ff || key_hit)) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end

      case (state_ff)
         // Sweep zeros through the ring after reset.
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = '0;
            idx_in    = idx_ff + AW'(1);
            if (idx_ff == LAST_ADDR) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               if (func_type'(req_func) == FUNC_RECORD) begin
                  ram_we = 1'b1;
                  wi_in  = oldest;
               end else begin
                  counting_in = 1'b1;
                  cnt_in      = '0;
                  idx_in      = '0;
                  issuing_in  = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end

         // Issue one read per cycle from the oldest entry to the newest.
         ST_SCAN: begin
            if (issuing_ff) begin
               dv_in = 1'b1;
               if (idx_ff == LAST_ADDR) begin
                  issuing_in = 1'b0;
               end else begin
                  idx_in     = idx_ff + AW'(1);
                  issuing_in = 1'b1;
               end
            end
            if (dv_ff && d_last_ff) begin
               state_in = ST_PASS_END;
            end
         end

         // Settle one key bit, or set up the bit passes after the count pass.
         ST_PASS_END: begin
            idx_in = '0;
            cnt_in = '0;
            if (counting_ff) begin
               total_in    = cnt_ff;
               rank_in     = cnt_ff >> 1;
               prefix_in   = '0;
               hi_mask_in  = '0;
               bit_in      = {1'b1, {(KW - 1){1'b0}}};
               counting_in = 1'b0;
               if (cnt_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  issuing_in = 1'b1;
                  state_in   = ST_SCAN;
               end
            end else begin
               if (rank_ff >= cnt_ff) begin
                  prefix_in = prefix_ff | bit_ff;
                  rank_in   = rank_ff - cnt_ff;
               end
               hi_mask_in = hi_mask_ff | bit_ff;
               bit_in     = bit_ff >> 1;
               if (bit_ff[0]) begin
                  state_in = ST_MAG;
               end else begin
                  issuing_in = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end

         ST_MAG: begin
            neg_in   = med_s[KW-1];
            mag_in   = med_s[KW-1] ? (MEDIAN_W'(0) - med_x) : med_x;
            state_in = ST_MUL_LO;
         end

         // Magnitude times scale in two 32-bit partial products.
         ST_MUL_LO: begin
            acc_in   = PROD_W'({32'd0, mag_ff[31:0]} * {32'd0, tick_scale_ff});
            state_in = ST_MUL_HI;
         end

         ST_MUL_HI: begin
            acc_in   = acc_ff + {{32'd0, mag_ff[63:32]} * {32'd0, tick_scale_ff}, 32'd0};
            state_in = ST_ROUND;
         end

         // Drop the fraction; a negative value with a fraction rounds away from zero.
         ST_ROUND: begin
            q_in     = acc_ff[PROD_W-1:16] +
                       QUOT_W'(neg_ff && (acc_ff[15:0] != 16'd0));
            state_in = ST_DONE;
         end

         // Saturate and load the response register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_has_in   = (total_ff != '0);
               rsp_count_in = (total_x > XCW'(PAIR_MAX)) ? PAIR_MAX : total_x[PAIR_W-1:0];
               if (total_ff == '0) begin
                  rsp_median_in = '0;
               end else if (!neg_ff) begin
                  rsp_median_in = (q_ff[QUOT_W-1:MEDIAN_W-1] != '0) ?
                                  MEDIAN_MAX : q_ff[MEDIAN_W-1:0];
               end else if ((q_ff[QUOT_W-1:MEDIAN_W] != '0) ||
                            (q_ff[MEDIAN_W-1] && (q_ff[MEDIAN_W-2:0] != '0))) begin
                  rsp_median_in = MEDIAN_MIN;
               end else begin
                  rsp_median_in = MEDIAN_W'(0) - q_ff[MEDIAN_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and registered outputs.
   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      cnt_ff        <= cnt_in;
      total_ff      <= total_in;
      rank_ff       <= rank_in;
      prefix_ff     <= prefix_in;
      hi_mask_ff    <= hi_mask_in;
      bit_ff        <= bit_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      acc_ff        <= acc_in;
      q_ff          <= q_in;
      rsp_median_ff <= rsp_median_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_count_ff  <= rsp_count_in;
      d_first_ff    <= d_first_in;
      d_last_ff     <= d_last_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         issuing_ff    <= 1'b0;
         dv_ff         <= 1'b0;
         counting_ff   <= 1'b0;
         wi_ff         <= LAST_ADDR;
         app_start_ff  <= '0;
         tick_scale_ff <= SCALE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         issuing_ff    <= issuing_in;
         dv_ff         <= dv_in;
         counting_ff   <= counting_in;
         wi_ff         <= wi_in;
         app_start_ff  <= app_start_in;
         tick_scale_ff <= tick_scale_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_scaled = rsp_median_ff;
   assign rsp_has_data      = rsp_has_ff;
   assign rsp_pair_count    = rsp_count_ff;

endmodule

[rtl/fdm_ram.sv]
module fdm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[bench/tb.sv]
module tb;
   import fdm_pkg::*;

   localparam int RING_DEPTH     = 128;
   localparam int TS_W           = 48;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 16;

   localparam logic [TS_W-1:0]    TS_MAX    = {TS_W{1'b1}};
   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

   // Saturation bounds at the width of the full product.
   localparam logic signed [PROD_W:0] MEDIAN_HI = {33'd0, MEDIAN_MAX};
   localparam logic signed [PROD_W:0] MEDIAN_LO = {{33{1'b1}}, MEDIAN_MIN};

   typedef struct packed {
      func_type        func;
      logic [TS_W-1:0] ts;
   } frame_req_type;

   typedef struct packed {
      logic signed [MEDIAN_W-1:0] median;
      logic                       has_data;
      logic [PAIR_W-1:0]          pair_count;
   } median_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic                       req_func      = 1'b0;
   logic [TS_W-1:0]            req_timestamp = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic signed [MEDIAN_W-1:0] rsp_median_scaled;
   logic                       rsp_has_data;
   logic [PAIR_W-1:0]          rsp_pair_count;
   logic                       csr_wen       = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_idx       = CSR_APP_START;
   logic [CSR_DATA_W-1:0]      csr_wdata     = '0;

   // Shadow copy of the block's state and registers.
   logic [TS_W-1:0]    tick_ring [0:RING_DEPTH-1];
   logic [PAIR_W-1:0]  newest_slot    = PAIR_W'(RING_DEPTH - 1);
   logic [TS_W-1:0]    cfg_app_start  = '0;
   logic [SCALE_W-1:0] cfg_tick_scale = SCALE_RESET;

   frame_req_type     pending_reqs [$];
   median_result_type expected_medians [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count    = 0;
   int stall_cycles  = 0;

   frame_delta_median_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_timestamp     (req_timestamp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_median_scaled (rsp_median_scaled),
      .rsp_has_data      (rsp_has_data),
      .rsp_pair_count    (rsp_pair_count),
      .csr_wen           (csr_wen),
      .csr_idx           (csr_idx),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [TS_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TS_W-1:0];
   endfunction

   // Upper median of the adjacent deltas, scaled by Q16.16 with floor and saturation.
   function automatic median_result_type compute_median();
      longint                   deltas [0:RING_DEPTH-1];
      int                       count;
      int                       j;
      longint                   key;
      logic [PAIR_W-1:0]        a;
      logic [PAIR_W-1:0]        b;
      logic signed [PROD_W:0]   m_ext;
      logic signed [PROD_W:0]   s_ext;
      logic signed [PROD_W:0]   prod;
      logic signed [PROD_W:0]   quot;
      median_result_type        r;
      count        = 0;
      r.median     = '0;
      r.has_data   = 1'b0;
      r.pair_count = '0;
      // Walk from the newest entry backwards; the wrap pair is skipped.
      for (int i = 0; i < RING_DEPTH - 1; i++) begin
         a = newest_slot - PAIR_W'(i);
         b = a - 1'b1;
         if (tick_ring[a] != 0 && tick_ring[b] != 0) begin
            deltas[count] = longint'({16'd0, tick_ring[a]}) - longint'({16'd0, tick_ring[b]});
            count++;
         end
      end
      if (count != 0) begin
         for (int i = 1; i < count; i++) begin
            key = deltas[i];
            j   = i;
            while (j > 0 && deltas[j-1] > key) begin
               deltas[j] = deltas[j-1];
               j--;
            end
            deltas[j] = key;
         end
         m_ext = deltas[count/2];
         s_ext = {65'd0, cfg_tick_scale};
         prod  = m_ext * s_ext;
         quot  = prod >>> 16;
         if (quot > MEDIAN_HI) begin
            r.median = MEDIAN_MAX;
         end else if (quot < MEDIAN_LO) begin
            r.median = MEDIAN_MIN;
         end else begin
            r.median = quot[MEDIAN_W-1:0];
         end
         r.has_data   = 1'b1;
         r.pair_count = (count > 127) ? PAIR_MAX : PAIR_W'(count);
      end
      return r;
   endfunction

   // Request driver: applies each accepted request to the shadow state.
   always @(posedge clock) begin : request_driver
      frame_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_func == FUNC_RECORD) begin
               newest_slot            = newest_slot + 1'b1;
               tick_ring[newest_slot] = req_timestamp - cfg_app_start;
            end else begin
               expected_medians.push_back(compute_median());
            end
         end
         if (req_valid && !req_ready) begin
            // Hold the request until it is taken.
         end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req      = pending_reqs.pop_front();
            req_valid     <= 1'b1;
            req_func      <= next_req.func;
            req_timestamp <= next_req.ts;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin : response_monitor
      median_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_medians.size() == 0) begin
               $error("response with no query waiting: median_scaled %0d",
                      $signed(rsp_median_scaled));
               fail_count++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_median_scaled !== want.median) begin
                  $error("median_scaled mismatch: expected %0d, actual %0d",
                         $signed(want.median), $signed(rsp_median_scaled));
                  fail_count++;
               end
               if (rsp_has_data !== want.has_data) begin
                  $error("has_data mismatch: expected %0d, actual %0d",
                         want.has_data, rsp_has_data);
                  fail_count++;
               end
               if (rsp_pair_count !== want.pair_count) begin
                  $error("pair_count mismatch: expected %0d, actual %0d",
                         want.pair_count, rsp_pair_count);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic push_request(input func_type f, input logic [TS_W-1:0] ts);
      frame_req_type r;
      r.func = f;
      r.ts   = ts;
      pending_reqs.push_back(r);
   endtask

   // A register write also updates the shadow copy; only done while idle.
   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      if (idx == CSR_APP_START) begin
         cfg_app_start = data[TS_W-1:0];
      end else begin
         cfg_tick_scale = data[SCALE_W-1:0];
      end
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every request is taken and every response has come back.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_medians.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly steady frame timestamps, with noise, jumps, drops and invalid records.
   task automatic add_random_requests(input int n);
      logic [TS_W-1:0] frame_ts;
      int              period;
      int              step;
      int              pick;
      frame_ts = cfg_app_start + TS_W'($urandom_range(1000, 1));
      period   = $urandom_range(40000, 16);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            push_request(FUNC_QUERY, rand48());
         end else if (pick < 18) begin
            push_request(FUNC_RECORD, rand48());
         end else if (pick < 20) begin
            push_request(FUNC_RECORD, cfg_app_start);
         end else begin
            if ($urandom_range(49) == 0) begin
               frame_ts = rand48();
            end
            step = period + $urandom_range(64) - 32;
            if ($urandom_range(19) == 0) begin
               step = step * 4;
            end
            frame_ts = frame_ts + TS_W'(step);
            push_request(FUNC_RECORD, frame_ts);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         tick_ring[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 54;

      // Empty ring, then a single valid entry: no pairs either time.
      push_request(FUNC_QUERY, rand48());
      push_request(FUNC_RECORD, TS_W'(100));
      push_request(FUNC_QUERY, TS_W'(0));
      wait_idle();

      // Largest start and scale: one negative pair saturates low.
      csr_write(CSR_APP_START, TS_MAX);
      csr_write(CSR_TICK_SCALE, CSR_DATA_W'(SCALE_MAX));
      push_request(FUNC_RECORD, TS_MAX);
      push_request(FUNC_RECORD, TS_MAX - 1'b1);
      push_request(FUNC_RECORD, TS_W'(0));
      push_request(FUNC_QUERY, TS_MAX);
      // A positive and a negative pair: the upper median saturates high.
      push_request(FUNC_RECORD, TS_MAX);
      push_request(FUNC_RECORD, TS_W'(0));
      push_request(FUNC_RECORD, TS_MAX - 1'b1);
      push_request(FUNC_QUERY, TS_W'(0));
      wait_idle();

      // Fractional scale on a negative delta rounds toward minus infinity.
      csr_write(CSR_APP_START, CSR_DATA_W'(1000));
      csr_write(CSR_TICK_SCALE, CSR_DATA_W'(32'h0000_8001));
      push_request(FUNC_RECORD, TS_W'(1000));
      push_request(FUNC_RECORD, TS_W'(1500));
      push_request(FUNC_RECORD, TS_W'(1200));
      push_request(FUNC_QUERY, rand48());
      wait_idle();

      // Zero scale: data present, value zero.
      csr_write(CSR_TICK_SCALE, '0);
      push_request(FUNC_QUERY, rand48());
      wait_idle();

      // Random phases with changing idle patterns and register settings.
      csr_write(CSR_APP_START, rand48());
      csr_write(CSR_TICK_SCALE, CSR_DATA_W'(SCALE_RESET));
      add_random_requests(250);
      wait_idle();

      send_idle_pct = 54;
      recv_idle_pct = 23;
      csr_write(CSR_APP_START, rand48());
      csr_write(CSR_TICK_SCALE, CSR_DATA_W'($urandom));
      add_random_requests(250);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_APP_START, '0);
      csr_write(CSR_TICK_SCALE, CSR_DATA_W'($urandom_range(32'h0004_0000, 1)));
      add_random_requests(250);
      wait_idle();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
